### rtl/core/atss_pkg.sv
// Shared types, constants and helper functions for the actuator test sequencer.
`default_nettype none
package atss_pkg;

    localparam int unsigned CODE_W     = 8;
    localparam int unsigned TICK_W     = 8;
    localparam int unsigned SP_W       = 16;
    localparam int unsigned PHASE_W    = 3;
    localparam int unsigned CHG_W      = 2;
    localparam int unsigned NUM_DELAYS = 5;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CODE_W-1:0] TEST_CODE      = 8'd1;
    localparam logic [TICK_W-1:0] END_HOLD_TICKS = 8'd10;
    localparam logic [TICK_W-1:0] SAT_TICKS      = 8'd250;
    localparam logic [SP_W-1:0]   SAT_SETPOINT   = 16'd32768;

    localparam logic [TICK_W-1:0] HOLD_LOAD =
        (END_HOLD_TICKS > SAT_TICKS) ? SAT_TICKS : END_HOLD_TICKS;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_DELAY_ONE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DELAY_TWO   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DELAY_THREE = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DELAY_FOUR  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_DELAY_FIVE  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SP_LOW      = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_SP_MID      = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SP_HIGH     = 3'd7;

    // external phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_ONE   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_TWO   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_THREE = 3'd3;
    localparam logic [PHASE_W-1:0] PH_FOUR  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_FIVE  = 3'd5;
    localparam logic [PHASE_W-1:0] PH_HOLD  = 3'd6;

    localparam logic [CHG_W-1:0] CHG_FIRST  = 2'd0;
    localparam logic [CHG_W-1:0] CHG_SECOND = 2'd1;
    localparam logic [CHG_W-1:0] CHG_THIRD  = 2'd2;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_ONE   = 7'b0000010,
        ST_TWO   = 7'b0000100,
        ST_THREE = 7'b0001000,
        ST_FOUR  = 7'b0010000,
        ST_FIVE  = 7'b0100000,
        ST_HOLD  = 7'b1000000
    } state_t;

    typedef struct packed {
        logic [NUM_DELAYS-1:0][TICK_W-1:0] delay;
        logic [SP_W-1:0]                   sp_low;
        logic [SP_W-1:0]                   sp_mid;
        logic [SP_W-1:0]                   sp_high;
    } cfg_t;

    // result item, last field in the lowest bits
    typedef struct packed {
        logic [TICK_W-1:0]  hold_left;
        logic [TICK_W-1:0]  delay_left;
        logic [CHG_W-1:0]   change_count;
        logic [TICK_W-1:0]  phase_duration;
        logic               complete;
        logic               in_progress;
        logic [SP_W-1:0]    setpoint;
        logic [PHASE_W-1:0] phase;
    } result_t;

    localparam int unsigned RESULT_W = $bits(result_t);
    localparam int unsigned M_DATA_W = ((RESULT_W + 7) / 8) * 8;
    localparam int unsigned S_DATA_W = ((CODE_W + 1 + 7) / 8) * 8;

    function automatic logic [TICK_W-1:0] sat_ticks(input logic [TICK_W-1:0] v);
        return (v > SAT_TICKS) ? SAT_TICKS : v;
    endfunction

    function automatic logic [SP_W-1:0] sat_sp(input logic [SP_W-1:0] v);
        return (v > SAT_SETPOINT) ? SAT_SETPOINT : v;
    endfunction

    function automatic logic [PHASE_W-1:0] phase_code(input state_t s);
        logic [PHASE_W-1:0] c;
        unique case (s)
            ST_IDLE:  c = PH_IDLE;
            ST_ONE:   c = PH_ONE;
            ST_TWO:   c = PH_TWO;
            ST_THREE: c = PH_THREE;
            ST_FOUR:  c = PH_FOUR;
            ST_FIVE:  c = PH_FIVE;
            ST_HOLD:  c = PH_HOLD;
            default:  c = PH_IDLE;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

### rtl/core/atss_cfg.sv
// Configuration register file for phase delays and setpoints.
`default_nettype none
module atss_cfg (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [atss_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [atss_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output atss_pkg::cfg_t                          cfg
);
    import atss_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                REG_DELAY_ONE:   cfg_next.delay[0] = cfg_wdata[TICK_W-1:0];
                REG_DELAY_TWO:   cfg_next.delay[1] = cfg_wdata[TICK_W-1:0];
                REG_DELAY_THREE: cfg_next.delay[2] = cfg_wdata[TICK_W-1:0];
                REG_DELAY_FOUR:  cfg_next.delay[3] = cfg_wdata[TICK_W-1:0];
                REG_DELAY_FIVE:  cfg_next.delay[4] = cfg_wdata[TICK_W-1:0];
                REG_SP_LOW:      cfg_next.sp_low   = cfg_wdata[SP_W-1:0];
                REG_SP_MID:      cfg_next.sp_mid   = cfg_wdata[SP_W-1:0];
                REG_SP_HIGH:     cfg_next.sp_high  = cfg_wdata[SP_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

### rtl/core/atss_seq.sv
// Test phase sequencer: state, counters and per-tick next-state logic.
`default_nettype none
module atss_seq (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           step,
    input  wire logic [atss_pkg::CODE_W-1:0]    test_code,
    input  wire logic                           service_enable,
    input  atss_pkg::cfg_t                      cfg,
    output atss_pkg::result_t                   res_next
);
    import atss_pkg::*;

    state_t              state_reg,    state_next;
    logic [TICK_W-1:0]   delay_reg,    delay_next;
    logic [TICK_W-1:0]   dur_reg,      dur_next;
    logic [TICK_W-1:0]   hold_reg,     hold_next;
    logic [SP_W-1:0]     sp_reg,       sp_next;
    logic                prog_reg,     prog_next;
    logic                cmpl_reg,     cmpl_next;
    logic [CHG_W-1:0]    chg_reg,      chg_next;

    logic ena;
    logic delay_done;
    logic [TICK_W-1:0] dur_inc;

    assign ena        = (test_code == TEST_CODE) && service_enable;
    assign delay_done = (delay_reg <= 8'd1);
    assign dur_inc    = (dur_reg < SAT_TICKS) ? dur_reg + 8'd1 : dur_reg;

    always_comb begin
        state_next = state_reg;
        delay_next = delay_reg;
        dur_next   = dur_reg;
        hold_next  = hold_reg;
        sp_next    = sp_reg;
        prog_next  = prog_reg;
        cmpl_next  = cmpl_reg;
        chg_next   = chg_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (ena) begin
                    state_next = ST_ONE;
                    prog_next  = 1'b1;
                    cmpl_next  = 1'b0;
                    delay_next = sat_ticks(cfg.delay[0]);
                    sp_next    = sat_sp(cfg.sp_low);
                    dur_next   = '0;
                    chg_next   = CHG_FIRST;
                end
            end
            ST_ONE: begin
                if (!ena) begin
                    state_next = ST_IDLE;
                    prog_next  = 1'b0;
                    cmpl_next  = 1'b0;
                end else if (delay_done) begin
                    state_next = ST_TWO;
                    delay_next = sat_ticks(cfg.delay[1]);
                    sp_next    = sat_sp(cfg.sp_mid);
                    dur_next   = '0;
                    chg_next   = CHG_SECOND;
                end else begin
                    delay_next = delay_reg - 8'd1;
                    dur_next   = '0;
                end
            end
            ST_TWO: begin
                if (!ena) begin
                    state_next = ST_IDLE;
                    prog_next  = 1'b0;
                    cmpl_next  = 1'b0;
                end else if (delay_done) begin
                    state_next = ST_THREE;
                    delay_next = sat_ticks(cfg.delay[2]);
                    sp_next    = sat_sp(cfg.sp_high);
                    dur_next   = '0;
                    chg_next   = CHG_SECOND;
                end else begin
                    delay_next = delay_reg - 8'd1;
                    dur_next   = dur_inc;
                end
            end
            ST_THREE: begin
                if (!ena) begin
                    state_next = ST_IDLE;
                    prog_next  = 1'b0;
                    cmpl_next  = 1'b0;
                end else if (delay_done) begin
                    state_next = ST_FOUR;
                    delay_next = sat_ticks(cfg.delay[3]);
                    sp_next    = sat_sp(cfg.sp_mid);
                    dur_next   = '0;
                    chg_next   = CHG_THIRD;
                end else begin
                    delay_next = delay_reg - 8'd1;
                    dur_next   = dur_inc;
                end
            end
            ST_FOUR: begin
                if (!ena) begin
                    state_next = ST_IDLE;
                    prog_next  = 1'b0;
                    cmpl_next  = 1'b0;
                end else if (delay_done) begin
                    state_next = ST_FIVE;
                    delay_next = sat_ticks(cfg.delay[4]);
                    sp_next    = sat_sp(cfg.sp_low);
                    dur_next   = '0;
                    chg_next   = CHG_THIRD;
                end else begin
                    delay_next = delay_reg - 8'd1;
                    dur_next   = dur_inc;
                end
            end
            ST_FIVE: begin
                if (!ena) begin
                    state_next = ST_IDLE;
                    prog_next  = 1'b0;
                    cmpl_next  = 1'b0;
                end else if (delay_done) begin
                    state_next = ST_HOLD;
                    hold_next  = HOLD_LOAD;
                    prog_next  = 1'b0;
                    cmpl_next  = 1'b1;
                    dur_next   = '0;
                    chg_next   = CHG_FIRST;
                end else begin
                    delay_next = delay_reg - 8'd1;
                    dur_next   = dur_inc;
                end
            end
            ST_HOLD: begin
                if (hold_reg <= 8'd1) begin
                    state_next = ST_IDLE;
                    prog_next  = 1'b0;
                    cmpl_next  = 1'b0;
                end else begin
                    hold_next = hold_reg - 8'd1;
                end
            end
            default: begin
                state_next = ST_IDLE;
                prog_next  = 1'b0;
                cmpl_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            delay_reg <= '0;
            dur_reg   <= '0;
            hold_reg  <= '0;
            sp_reg    <= '0;
            prog_reg  <= 1'b0;
            cmpl_reg  <= 1'b0;
            chg_reg   <= '0;
        end else if (step) begin
            state_reg <= state_next;
            delay_reg <= delay_next;
            dur_reg   <= dur_next;
            hold_reg  <= hold_next;
            sp_reg    <= sp_next;
            prog_reg  <= prog_next;
            cmpl_reg  <= cmpl_next;
            chg_reg   <= chg_next;
        end
    end

    assign res_next.phase          = phase_code(state_next);
    assign res_next.setpoint       = sp_next;
    assign res_next.in_progress    = prog_next;
    assign res_next.complete       = cmpl_next;
    assign res_next.phase_duration = dur_next;
    assign res_next.change_count   = chg_next;
    assign res_next.delay_left     = delay_next;
    assign res_next.hold_left      = hold_next;

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(prog_reg && cmpl_reg))
        else $error("in_progress and complete both set");

    a_progress_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        prog_reg == (state_reg == ST_ONE || state_reg == ST_TWO || state_reg == ST_THREE
                     || state_reg == ST_FOUR || state_reg == ST_FIVE))
        else $error("in_progress flag disagrees with phase");

    a_complete_matches_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        cmpl_reg == (state_reg == ST_HOLD))
        else $error("complete flag disagrees with end hold");

    a_counters_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        dur_reg <= SAT_TICKS && delay_reg <= SAT_TICKS && hold_reg <= SAT_TICKS)
        else $error("counter exceeds saturation limit");

    a_idle_step_holds_counters: assert property (@(posedge aclk) disable iff (!aresetn)
        step && state_reg == ST_IDLE && !ena |=> $stable(delay_reg) && $stable(sp_reg))
        else $error("idle tick changed counters");

endmodule
`default_nettype wire

### rtl/core/atss_out.sv
// Result register stage with valid/ready handshake toward the sink.
`default_nettype none
module atss_out (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         load,
    input  atss_pkg::result_t                 res_in,
    output logic                              room,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [atss_pkg::M_DATA_W-1:0]     m_tdata
);
    import atss_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign room = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res_in;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(M_DATA_W-RESULT_W){1'b0}}, data_reg};

endmodule
`default_nettype wire

### rtl/core/actuator_test_setpoint_sequencer_unit.sv
// Actuator test setpoint sequencer: input register, sequencer and result register.
//
// One input transfer is one tick: s_tdata carries the test code and the
// service enable. Each accepted tick produces exactly one result transfer on
// the m_ side that shows the sequence state after that tick: phase, setpoint,
// progress and completion flags, and the phase/delay/hold counters.
// Phase delays and setpoints are set via the cfg_we/cfg_addr/cfg_wdata write port,
// one register per write, by the user only while no tick is in flight (unchecked).
// A tick passes through the input register and then the result register before
// its result is valid. Throughput is one tick per cycle while the sink keeps up;
// the state update is a few compares and 8-bit counters between the two
// registers.
// When the sink stalls, the result register holds its transfer and the input
// register keeps one more tick, after which s_tready drops until the sink
// takes the result.
// Reset (aresetn low, synchronous) clears the sequence to idle, zeroes all
// counters, the setpoint and every configuration register, and empties both
// register stages.
`default_nettype none
module actuator_test_setpoint_sequencer_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // s_tdata: [7:0] test_code, [8] service_enable
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [atss_pkg::S_DATA_W-1:0]  s_tdata,
    // m_tdata: [2:0] phase, [18:3] setpoint, [19] in_progress, [20] complete,
    //          [28:21] phase_duration, [30:29] change_count,
    //          [38:31] delay_left, [46:39] hold_left
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [atss_pkg::M_DATA_W-1:0]       m_tdata,
    input  wire logic                           cfg_we,
    input  wire logic [atss_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [atss_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import atss_pkg::*;

    logic              in_valid_reg, in_valid_next;
    logic [CODE_W-1:0] in_code_reg;
    logic              in_en_reg;
    logic              room;
    logic              advance;
    cfg_t              cfg;
    result_t           res_next;

    assign advance  = in_valid_reg && room;
    assign s_tready = !in_valid_reg || room;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_code_reg <= s_tdata[CODE_W-1:0];
            in_en_reg   <= s_tdata[CODE_W];
        end
    end

    atss_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    atss_seq u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (advance),
        .test_code      (in_code_reg),
        .service_enable (in_en_reg),
        .cfg            (cfg),
        .res_next       (res_next)
    );

    atss_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .res_in   (res_next),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

### sim/atss_sequence_checker.sv
// Checker for the actuator test sequencer: predicts each tick's status and compares results.
module atss_sequence_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [atss_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [atss_pkg::M_DATA_W-1:0]   m_tdata,
    input  wire logic                            cfg_we,
    input  wire logic [atss_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [atss_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                                   fail_count,
    output int                                   ticks_in,
    output int                                   results_out
);
    import atss_pkg::*;

    localparam int PRINT_CAP = 100;

    result_t status_q[$];
    result_t next_status, want, got;

    logic [PHASE_W-1:0] seq_ph;
    logic [TICK_W-1:0]  dly_left;
    logic [TICK_W-1:0]  dur_ticks;
    logic [TICK_W-1:0]  hold_left;
    logic [SP_W-1:0]    sp_now;
    logic               running;
    logic               done_flag;
    logic [CHG_W-1:0]   chg_idx;

    logic [NUM_DELAYS-1:0][TICK_W-1:0] dly_cfg;
    logic [SP_W-1:0] sp_low_cfg, sp_mid_cfg, sp_high_cfg;

    int result_idx;

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("%0t: result %0d: %s", $time, result_idx, msg);
    endtask

    task automatic check_field(input string name, input logic [SP_W-1:0] got_v,
                               input logic [SP_W-1:0] want_v);
        if (got_v !== want_v)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got_v, want_v));
    endtask

    task automatic drop_to_idle();
        seq_ph    = PH_IDLE;
        running   = 1'b0;
        done_flag = 1'b0;
    endtask

    task automatic enter_phase(input logic [PHASE_W-1:0] ph, input logic [TICK_W-1:0] dly,
                               input logic [SP_W-1:0] sp, input logic [CHG_W-1:0] chg);
        seq_ph    = ph;
        dly_left  = (dly > SAT_TICKS) ? SAT_TICKS : dly;
        sp_now    = (sp > SAT_SETPOINT) ? SAT_SETPOINT : sp;
        dur_ticks = '0;
        chg_idx   = chg;
    endtask

    task automatic count_down();
        dly_left = dly_left - 1'b1;
        if (dur_ticks < SAT_TICKS)
            dur_ticks = dur_ticks + 1'b1;
    endtask

    task automatic step_sequence(input logic [CODE_W-1:0] code, input logic svc_en,
                                 output result_t res);
        logic ena;
        ena = (code == TEST_CODE) && svc_en;
        case (seq_ph)
            PH_IDLE: begin
                if (ena) begin
                    running   = 1'b1;
                    done_flag = 1'b0;
                    enter_phase(PH_ONE, dly_cfg[0], sp_low_cfg, CHG_FIRST);
                end
            end
            PH_ONE: begin
                if (!ena) begin
                    drop_to_idle();
                end else if (dly_left <= 1) begin
                    enter_phase(PH_TWO, dly_cfg[1], sp_mid_cfg, CHG_SECOND);
                end else begin
                    dly_left  = dly_left - 1'b1;
                    dur_ticks = '0;
                end
            end
            PH_TWO: begin
                if (!ena) drop_to_idle();
                else if (dly_left <= 1) enter_phase(PH_THREE, dly_cfg[2], sp_high_cfg, CHG_SECOND);
                else count_down();
            end
            PH_THREE: begin
                if (!ena) drop_to_idle();
                else if (dly_left <= 1) enter_phase(PH_FOUR, dly_cfg[3], sp_mid_cfg, CHG_THIRD);
                else count_down();
            end
            PH_FOUR: begin
                if (!ena) drop_to_idle();
                else if (dly_left <= 1) enter_phase(PH_FIVE, dly_cfg[4], sp_low_cfg, CHG_THIRD);
                else count_down();
            end
            PH_FIVE: begin
                if (!ena) begin
                    drop_to_idle();
                end else if (dly_left <= 1) begin
                    seq_ph    = PH_HOLD;
                    hold_left = (END_HOLD_TICKS > SAT_TICKS) ? SAT_TICKS : END_HOLD_TICKS;
                    running   = 1'b0;
                    done_flag = 1'b1;
                    dur_ticks = '0;
                    chg_idx   = CHG_FIRST;
                end else begin
                    count_down();
                end
            end
            PH_HOLD: begin
                if (hold_left <= 1) drop_to_idle();
                else hold_left = hold_left - 1'b1;
            end
            default: drop_to_idle();
        endcase
        res.phase          = seq_ph;
        res.setpoint       = sp_now;
        res.in_progress    = running;
        res.complete       = done_flag;
        res.phase_duration = dur_ticks;
        res.change_count   = chg_idx;
        res.delay_left     = dly_left;
        res.hold_left      = hold_left;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            status_q.delete();
            seq_ph      = PH_IDLE;
            dly_left    = '0;
            dur_ticks   = '0;
            hold_left   = '0;
            sp_now      = '0;
            running     = 1'b0;
            done_flag   = 1'b0;
            chg_idx     = CHG_FIRST;
            dly_cfg     = '0;
            sp_low_cfg  = '0;
            sp_mid_cfg  = '0;
            sp_high_cfg = '0;
            fail_count  = 0;
            result_idx  = 0;
            ticks_in    <= 0;
            results_out <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_DELAY_ONE:   dly_cfg[0]  = cfg_wdata[TICK_W-1:0];
                    REG_DELAY_TWO:   dly_cfg[1]  = cfg_wdata[TICK_W-1:0];
                    REG_DELAY_THREE: dly_cfg[2]  = cfg_wdata[TICK_W-1:0];
                    REG_DELAY_FOUR:  dly_cfg[3]  = cfg_wdata[TICK_W-1:0];
                    REG_DELAY_FIVE:  dly_cfg[4]  = cfg_wdata[TICK_W-1:0];
                    REG_SP_LOW:      sp_low_cfg  = cfg_wdata;
                    REG_SP_MID:      sp_mid_cfg  = cfg_wdata;
                    REG_SP_HIGH:     sp_high_cfg = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                results_out <= results_out + 1;
                if (status_q.size() == 0) begin
                    report_mismatch("result transfer with no tick pending");
                end else begin
                    want = status_q.pop_front();
                    got  = m_tdata[RESULT_W-1:0];
                    check_field("phase", SP_W'(got.phase), SP_W'(want.phase));
                    check_field("setpoint", got.setpoint, want.setpoint);
                    check_field("in_progress", SP_W'(got.in_progress),
                                SP_W'(want.in_progress));
                    check_field("complete", SP_W'(got.complete), SP_W'(want.complete));
                    check_field("phase_duration", SP_W'(got.phase_duration),
                                SP_W'(want.phase_duration));
                    check_field("change_count", SP_W'(got.change_count),
                                SP_W'(want.change_count));
                    check_field("delay_left", SP_W'(got.delay_left), SP_W'(want.delay_left));
                    check_field("hold_left", SP_W'(got.hold_left), SP_W'(want.hold_left));
                end
                result_idx++;
            end
            if (s_tvalid && s_tready) begin
                step_sequence(s_tdata[CODE_W-1:0], s_tdata[CODE_W], next_status);
                status_q.push_back(next_status);
                ticks_in <= ticks_in + 1;
            end
        end
    end

endmodule

### sim/tb_top.sv
// Testbench top: drives ticks and register writes into the sequencer and reports the verdict.
module tb_top;
    import atss_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_CYCLES    = 4;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    wire logic             s_tready;
    wire logic             m_tvalid;
    wire logic [M_DATA_W-1:0] m_tdata;

    int fail_count;
    int ticks_in;
    int results_out;
    int cycles        = 0;
    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    bit hold_off_req  = 1'b0;

    actuator_test_setpoint_sequencer_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    atss_sequence_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .ticks_in    (ticks_in),
        .results_out (results_out)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // hold off on request, else stall at the current rate
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(posedge aclk);
                hold_off_req = 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rcv_stall_pct);
            end
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic program_regs(input logic [NUM_DELAYS-1:0][TICK_W-1:0] dly,
                                input logic [SP_W-1:0] lo, input logic [SP_W-1:0] mid,
                                input logic [SP_W-1:0] hi);
        write_reg(REG_DELAY_ONE, dly[0]);
        write_reg(REG_DELAY_TWO, dly[1]);
        write_reg(REG_DELAY_THREE, dly[2]);
        write_reg(REG_DELAY_FOUR, dly[3]);
        write_reg(REG_DELAY_FIVE, dly[4]);
        write_reg(REG_SP_LOW, lo);
        write_reg(REG_SP_MID, mid);
        write_reg(REG_SP_HIGH, hi);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [TICK_W-1:0] pick_delay();
        if ($urandom_range(99) < 8)
            return TICK_W'($urandom_range(245, 255));
        return TICK_W'($urandom_range(0, 6));
    endfunction

    task automatic program_random();
        program_regs({pick_delay(), pick_delay(), pick_delay(), pick_delay(), pick_delay()},
                     SP_W'($urandom), SP_W'($urandom), SP_W'($urandom));
    endtask

    task automatic send_tick(input logic [CODE_W-1:0] code, input logic svc_en);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W-CODE_W-1){1'b0}}, svc_en, code};
        do @(posedge aclk); while (!s_tready);
    endtask

    // mostly enabled ticks so sequences run through; a few noise ticks abort
    task automatic run_random(input int n);
        repeat (n) begin
            if ($urandom_range(99) < 4)
                send_tick(CODE_W'($urandom), 1'($urandom));
            else
                send_tick(TEST_CODE, 1'b1);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_out != ticks_in) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_rates(input int idle_pct, input int stall_pct);
        snd_idle_pct  = idle_pct;
        rcv_stall_pct = stall_pct;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // delays 0,1,2,3,2; setpoints above, at and just over the clamp
        program_regs({8'd2, 8'd3, 8'd2, 8'd1, 8'd0}, 16'hFFFF, 16'd32768, 16'd32769);
        send_tick(8'd0, 1'b1);
        send_tick(8'd255, 1'b1);
        send_tick(TEST_CODE, 1'b0);
        send_tick(8'd254, 1'b0);
        repeat (10) send_tick(TEST_CODE, 1'b1);
        repeat (10) send_tick(8'd0, 1'b0);
        repeat (2) send_tick(TEST_CODE, 1'b1);
        send_tick(8'd0, 1'b1);
        settle();

        set_rates(0, 0);
        program_random();
        run_random(350);
        settle();

        set_rates(70, 0);
        program_random();
        run_random(350);
        settle();

        set_rates(0, 70);
        program_random();
        run_random(350);
        settle();

        set_rates(27, 27);
        program_random();
        run_random(175);
        settle();
        run_random(175);
        settle();

        set_rates(0, 0);
        program_regs({5{8'd255}}, 16'hFFFF, 16'd0, 16'd32768);
        run_random(300);
        settle();

        program_regs('0, 16'd0, 16'd0, 16'd0);
        hold_off_req = 1'b1;
        run_random(150);
        settle();

        repeat (10) @(posedge aclk);
        if (fail_count == 0 && results_out == ticks_in) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
